[src/atb_pkg.sv]
// ----------------------------------------------------------------------------
// atb_pkg: shared types and constants of the alarm two-tone burst generator
// Request and sample payloads, sequencer states, pattern timing constants
// and the elaboration-time sine table function.
// ----------------------------------------------------------------------------
`default_nettype none

package atb_pkg;

  typedef struct packed {
    logic [6:0] frame_count;
    logic       restart;
  } atb_req_t;

  typedef struct packed {
    logic signed [14:0] sample;
    logic [1:0]         burst;
    logic               last;
  } atb_smp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FRAME,
    ST_DIVP,
    ST_DIVE,
    ST_ROM,
    ST_SCALE,
    ST_SHAPE,
    ST_LOAD
  } atb_state_t;

  localparam logic [1:0] BURST_NONE = 2'd0;
  localparam logic [1:0] BURST_LOW  = 2'd1;
  localparam logic [1:0] BURST_HIGH = 2'd2;

  localparam int          STEP_W     = 22;
  localparam logic [21:0] STEP_RESET = 22'd349525;

  // pattern time in Q10.24 ms
  localparam logic [33:0] PERIOD_Q  = 34'd980 << 24;
  localparam logic [33:0] ON_Q      = 34'd200 << 24;
  localparam logic [33:0] B_START_Q = 34'd280 << 24;
  localparam logic [33:0] B_END_Q   = 34'd480 << 24;
  localparam logic [31:0] ON_L      = 32'd200 << 24;
  localparam logic [31:0] EDGE_L    = 32'd5 << 24;
  localparam logic [31:0] FADE_L    = 32'd195 << 24;

  // floor(x / 5) == (x * RECIP5) >> 34 for any 32-bit x
  localparam logic [31:0] RECIP5   = 32'hCCCC_CCCD;
  localparam logic [31:0] PEAK_Q15 = 32'd14746;

  localparam logic [63:0] Q30_ONE    = 64'd1 << 30;
  localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

  // table entry for turn fraction a (Q0.32): bit 15 sign, bits 14:0 magnitude
  function automatic logic [15:0] sine_word(input logic [63:0] a);
    logic [1:0]  quad;
    logic [63:0] r;
    logic [63:0] q;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] v;
    logic [15:0] w;
    quad = a[31:30];
    r    = {34'd0, a[29:0]};
    q    = quad[0] ? (Q30_ONE - r) : r;
    x    = (q * TWO_PI_Q30) >> 32;
    x2   = (x * x) >> 30;
    t    = Q30_ONE - x2 / 64'd110;
    t    = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
    t    = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
    t    = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
    t    = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
    s    = (x * t) >> 30;
    v    = (s + 64'd16384) >> 15;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    w[14:0] = v[14:0];
    w[15]   = quad[1];
    return w;
  endfunction

endpackage

`default_nettype wire

[src/atb_sine_rom.sv]
// ----------------------------------------------------------------------------
// atb_sine_rom: one-period sine table
// Entries are built at elaboration; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module atb_sine_rom
  import atb_pkg::*;
#(
  parameter int SINE_TABLE_DEPTH = 256,
  parameter int AW               = 8
) (
  input  wire logic          clk,
  input  wire logic [AW-1:0] addr,
  output logic      [15:0]   word
);

  logic [15:0] rom_tab [SINE_TABLE_DEPTH];

  for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_entry
    localparam logic [63:0] TURN = (64'(k) << 32) / SINE_TABLE_DEPTH;
    assign rom_tab[k] = sine_word(TURN);
  end

  always_ff @(posedge clk) begin
    word <= rom_tab[addr];
  end

endmodule

`default_nettype wire

[src/atb_mul_unit.sv]
// ----------------------------------------------------------------------------
// atb_mul_unit: shared 32 x 32 multiplier
// Product is registered and held until the next enabled cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module atb_mul_unit (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic      [63:0] prod
);

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= {32'd0, a} * {32'd0, b};
    end
  end

endmodule

`default_nettype wire

[src/alarm_two_tone_burst_generator.sv]
// ----------------------------------------------------------------------------
// alarm_two_tone_burst_generator: two-tone alarm cadence sample source
// 980 ms cadence of 1000 Hz burst, gap, 1200 Hz burst and silence, shaped by
// a 5 ms linear attack and release, one 15-bit signed sample per frame (Q0.15 scale, 2^-15 per LSB).
//
//   channel   direction   payload      handshake
//   req       in          atb_req_t    req_valid / req_ready
//   smp       out         atb_smp_t    smp_valid / smp_ready
//   cfg       in          22-bit step  cfg_valid / cfg_ready
//
// a request is taken whenever the sequencer is idle
// a tone frame steps through the frame, divp, dive, rom, scale, shape and load states,
// a silent frame only through frame and load; every product uses the one shared multiplier
// a stalled sample holds the sequencer in its load step; no clearing pass
// after reset, pattern time starts at zero and the step at 48 kHz
// ----------------------------------------------------------------------------
`default_nettype none

module alarm_two_tone_burst_generator
  import atb_pkg::*;
#(
  parameter int MAX_FRAMES       = 64,
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  output logic             req_ready,
  input  wire atb_req_t    req_data,
  output logic             smp_valid,
  input  wire logic        smp_ready,
  output atb_smp_t         smp_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [21:0] cfg_data
);

  localparam int CW = $clog2(MAX_FRAMES + 1);
  localparam int AW = (SINE_TABLE_DEPTH > 1) ? $clog2(SINE_TABLE_DEPTH) : 1;
  localparam int IW = 24 + AW;

  atb_state_t state, state_next;

  logic [33:0]       pattern_time;
  logic [STEP_W-1:0] step;
  logic [CW-1:0]     remaining;
  logic [31:0]       local_t;
  logic [1:0]        burst;
  logic [26:0]       edge_t;
  logic [16:0]       env16;
  logic [AW-1:0]     rom_addr;
  logic [15:0]       rom_word;

  logic        mul_en;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;

  logic        req_fire;
  logic        slot_free;
  logic        load_go;
  logic [6:0]  count_clamped;

  logic [1:0]  seg_burst;
  logic [31:0] seg_local;
  logic [26:0] edge_calc;
  logic [23:0] frac;
  logic [IW-1:0] idx_prod;
  logic [46:0] rnd;
  logic [14:0] mag;
  logic [34:0] time_sum;
  logic [34:0] time_wrap;

  assign cfg_ready = 1'b1;
  assign req_fire  = req_valid && req_ready;
  assign slot_free = !smp_valid || smp_ready;
  assign load_go   = (state == ST_LOAD) && slot_free;

  assign count_clamped = (req_data.frame_count > 7'(MAX_FRAMES)) ? 7'(MAX_FRAMES)
                                                                   : req_data.frame_count;

  // segment and time within the burst
  always_comb begin
    seg_burst = BURST_NONE;
    seg_local = pattern_time[31:0];
    if (pattern_time < ON_Q) begin
      seg_burst = BURST_LOW;
    end else if (pattern_time >= B_START_Q && pattern_time < B_END_Q) begin
      seg_burst = BURST_HIGH;
      seg_local = 32'(pattern_time - B_START_Q);
    end
  end

  // attack and release ramp position
  always_comb begin
    if (local_t < EDGE_L) begin
      edge_calc = local_t[26:0];
    end else if (local_t > FADE_L) begin
      edge_calc = 27'(ON_L - local_t);
    end else begin
      edge_calc = EDGE_L[26:0];
    end
  end

  // high tone phase is local + local / 5, only the fraction of a turn matters
  assign frac     = local_t[23:0] + ((burst == BURST_HIGH) ? prod[57:34] : 24'd0);
  assign idx_prod = IW'(frac) * IW'(SINE_TABLE_DEPTH);

  assign rnd = {1'b0, prod[45:0]} + (47'd1 << 30);
  assign mag = rnd[45:31];

  assign time_sum  = {1'b0, pattern_time} + 35'(step);
  assign time_wrap = (time_sum >= {1'b0, PERIOD_Q}) ? time_sum - {1'b0, PERIOD_Q} : time_sum;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_fire && count_clamped != 7'd0) begin
          state_next = ST_FRAME;
        end
      end
      ST_FRAME: begin
        state_next = (seg_burst == BURST_NONE) ? ST_LOAD : ST_DIVP;
      end
      ST_DIVP:  state_next = ST_DIVE;
      ST_DIVE:  state_next = ST_ROM;
      ST_ROM:   state_next = ST_SCALE;
      ST_SCALE: state_next = ST_SHAPE;
      ST_SHAPE: state_next = ST_LOAD;
      ST_LOAD: begin
        if (slot_free) begin
          state_next = (remaining == CW'(1)) ? ST_IDLE : ST_FRAME;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs: request side and multiplier operands
  always_comb begin
    req_ready = 1'b0;
    mul_en    = 1'b0;
    mul_a     = 32'd0;
    mul_b     = 32'd0;
    unique case (state)
      ST_IDLE: req_ready = 1'b1;
      ST_DIVP: begin
        mul_en = 1'b1;
        mul_a  = local_t;
        mul_b  = RECIP5;
      end
      ST_DIVE: begin
        // env16 = floor(e / 1280) = floor((e >> 8) / 5)
        mul_en = 1'b1;
        mul_a  = {13'd0, edge_t[26:8]};
        mul_b  = RECIP5;
      end
      ST_SCALE: begin
        mul_en = 1'b1;
        mul_a  = {17'd0, rom_word[14:0]};
        mul_b  = PEAK_Q15;
      end
      ST_SHAPE: begin
        mul_en = 1'b1;
        mul_a  = {3'd0, prod[28:0]};
        mul_b  = {15'd0, env16};
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      pattern_time <= 34'd0;
      step         <= STEP_RESET;
      remaining    <= '0;
      smp_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        step <= cfg_data;
      end
      if (req_fire) begin
        remaining <= CW'(count_clamped);
        if (req_data.restart) begin
          pattern_time <= 34'd0;
        end
      end
      if (load_go) begin
        smp_valid    <= 1'b1;
        remaining    <= remaining - CW'(1);
        pattern_time <= time_wrap[33:0];
      end else if (smp_valid && smp_ready) begin
        smp_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == ST_FRAME) begin
      local_t <= seg_local;
      burst   <= seg_burst;
    end
    if (state == ST_DIVP) begin
      edge_t <= edge_calc;
    end
    if (state == ST_DIVE) begin
      rom_addr <= idx_prod[IW-1:24];
    end
    if (state == ST_ROM) begin
      env16 <= prod[50:34];
    end
    if (load_go) begin
      smp_data.burst <= burst;
      smp_data.last  <= (remaining == CW'(1));
      if (burst == BURST_NONE) begin
        smp_data.sample <= 15'sd0;
      end else if (rom_word[15]) begin
        smp_data.sample <= $signed(15'd0 - mag);
      end else begin
        smp_data.sample <= $signed(mag);
      end
    end
  end

  atb_sine_rom #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH),
    .AW              (AW)
  ) u_rom (
    .clk (clk),
    .addr(rom_addr),
    .word(rom_word)
  );

  atb_mul_unit u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .prod(prod)
  );

endmodule

`default_nettype wire

[tb/alarm_two_tone_burst_generator_test.sv]
// ----------------------------------------------------------------------------
// alarm_two_tone_burst_generator_test: cadence and waveform check
// Drives frame requests and step-register writes into the burst generator
// under random source gaps and sink stalls. A scoreboard class keeps its own
// pattern clock and sine table and checks every returned sample in order.
// ----------------------------------------------------------------------------
module alarm_two_tone_burst_generator_test;
  import atb_pkg::*;

  localparam int TONE_DEPTH    = 256;
  localparam int FRAME_LIMIT   = 64;
  localparam int SETTLE_CYCLES = 20;
  localparam int REPORT_LIMIT  = 100;

  localparam bit [21:0] STEP_48K     = 22'd349525;
  localparam bit [21:0] STEP_LOWEST  = 22'd87381;
  localparam bit [21:0] STEP_HIGHEST = 22'd2097152;
  localparam bit [21:0] STEP_ALL_ONE = 22'h3FFFFF;
  localparam bit [21:0] STEP_FROZEN  = 22'd0;

  // pattern timing in Q10.24 ms
  localparam bit [63:0] MS_UNIT   = 64'd1 << 24;
  localparam bit [63:0] CYCLE_LEN = 64'd980 * MS_UNIT;
  localparam bit [63:0] TONE_LEN  = 64'd200 * MS_UNIT;
  localparam bit [63:0] HI_START  = 64'd280 * MS_UNIT;
  localparam bit [63:0] HI_END    = 64'd480 * MS_UNIT;
  localparam bit [63:0] RAMP_LEN  = 64'd5 * MS_UNIT;
  localparam bit [63:0] PEAK      = 64'd14746;
  localparam bit [63:0] ONE_Q30   = 64'd1 << 30;
  localparam bit [63:0] TAU_Q30   = 64'd6746518852;

  class cadence_checker;
    int signed sine_tab[TONE_DEPTH];
    bit [63:0] clock_ms;
    bit [21:0] step;
    atb_smp_t  pending[$];
    int        errors;

    function new();
      bit [63:0] a;
      bit [63:0] r;
      bit [63:0] q;
      bit [63:0] x;
      bit [63:0] x2;
      bit [63:0] t;
      bit [63:0] v;
      bit [1:0]  quad;
      clock_ms = '0;
      step     = STEP_48K;
      errors   = 0;
      // quarter-wave taylor series in Q2.30, folded into four quadrants
      for (int k = 0; k < TONE_DEPTH; k++) begin
        a    = (64'(k) << 32) / TONE_DEPTH;
        quad = a[31:30];
        r    = a & (ONE_Q30 - 1);
        q    = quad[0] ? (ONE_Q30 - r) : r;
        x    = (q * TAU_Q30) >> 32;
        x2   = (x * x) >> 30;
        t    = ONE_Q30 - x2 / 110;
        t    = ONE_Q30 - ((x2 * t) >> 30) / 72;
        t    = ONE_Q30 - ((x2 * t) >> 30) / 42;
        t    = ONE_Q30 - ((x2 * t) >> 30) / 20;
        t    = ONE_Q30 - ((x2 * t) >> 30) / 6;
        v    = (((x * t) >> 30) + 64'd16384) >> 15;
        if (v > 64'd32767) begin
          v = 64'd32767;
        end
        sine_tab[k] = quad[1] ? -int'(v) : int'(v);
      end
    endfunction

    function void set_step(bit [21:0] value);
      step = value;
    endfunction

    // offset is time since the burst began; the upper tone runs 6/5 as fast
    function bit [14:0] tone_sample(bit [63:0] offset, bit upper);
      bit [63:0] phase;
      bit [63:0] idx;
      bit [63:0] ramp;
      bit [63:0] env;
      bit [63:0] amp;
      bit [63:0] mag;
      int signed s;
      phase = upper ? (offset * 6) / 5 : offset;
      idx   = ((phase & (MS_UNIT - 1)) * TONE_DEPTH) >> 24;
      if (idx >= TONE_DEPTH) begin
        idx = TONE_DEPTH - 1;
      end
      s = sine_tab[idx];
      if (offset < RAMP_LEN) begin
        ramp = offset;
      end else if (offset > TONE_LEN - RAMP_LEN) begin
        ramp = TONE_LEN - offset;
      end else begin
        ramp = RAMP_LEN;
      end
      env = (ramp << 16) / RAMP_LEN;
      amp = (s < 0) ? -s : s;
      mag = (amp * PEAK * env + (64'd1 << 30)) >> 31;
      return (s < 0) ? 15'(64'd0 - mag) : 15'(mag);
    endfunction

    function void note_request(atb_req_t r);
      int unsigned n;
      atb_smp_t    e;
      if (r.restart) begin
        clock_ms = '0;
      end
      n = (r.frame_count > FRAME_LIMIT) ? FRAME_LIMIT : r.frame_count;
      for (int i = 0; i < n; i++) begin
        e.sample = '0;
        e.burst  = BURST_NONE;
        if (clock_ms < TONE_LEN) begin
          e.burst  = BURST_LOW;
          e.sample = tone_sample(clock_ms, 1'b0);
        end else if (clock_ms >= HI_START && clock_ms < HI_END) begin
          e.burst  = BURST_HIGH;
          e.sample = tone_sample(clock_ms - HI_START, 1'b1);
        end
        e.last = (i == n - 1);
        pending.push_back(e);
        clock_ms = clock_ms + step;
        if (clock_ms >= CYCLE_LEN) begin
          clock_ms = clock_ms - CYCLE_LEN;
        end
      end
    endfunction

    function void report(string what, int want, int got);
      errors++;
      if (errors <= REPORT_LIMIT) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      end
    endfunction

    function void check_sample(atb_smp_t got);
      atb_smp_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT) begin
          $display("%0t: unexpected sample, expected none, actual %0d/%0d/%0d",
                   $time, got.sample, got.burst, got.last);
        end
        return;
      end
      want = pending.pop_front();
      if (got.sample !== want.sample) begin
        report("sample", want.sample, got.sample);
      end
      if (got.burst !== want.burst) begin
        report("burst", want.burst, got.burst);
      end
      if (got.last !== want.last) begin
        report("last", want.last, got.last);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_ready;
  atb_req_t    req_data = '0;
  logic        smp_valid;
  logic        smp_ready = 1'b0;
  atb_smp_t    smp_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [21:0] cfg_data = '0;

  cadence_checker sb = new();
  int idle_rate = 0;  // 1 in idle_rate chance of a gap, 0 for none
  int sink_wait = 0;

  alarm_two_tone_burst_generator #(
    .MAX_FRAMES       (FRAME_LIMIT),
    .SINE_TABLE_DEPTH (TONE_DEPTH)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .smp_valid (smp_valid),
    .smp_ready (smp_ready),
    .smp_data  (smp_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // sink stalls in bursts of random length
  always @(negedge clk) begin
    if (sink_wait != 0) begin
      sink_wait = sink_wait - 1;
    end else if (idle_rate != 0 && $urandom_range(1, idle_rate) == 1) begin
      sink_wait = $urandom_range(1, 11);
    end
    smp_ready = (sink_wait == 0);
  end

  always @(posedge clk) begin
    if (!rst && smp_valid && smp_ready) begin
      sb.check_sample(smp_data);
    end
  end

  task automatic send_request(input logic [6:0] count, input logic again);
    @(negedge clk);
    if (idle_rate != 0 && $urandom_range(1, idle_rate) == 1) begin
      req_valid = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    req_data.frame_count = count;
    req_data.restart     = again;
    req_valid            = 1'b1;
    do @(posedge clk); while (!req_ready);
    sb.note_request(req_data);
  endtask

  task automatic send_random();
    logic [6:0] n;
    int         pick;
    pick = $urandom_range(0, 19);
    if (pick < 2) begin
      n = '0;
    end else if (pick < 4) begin
      n = $urandom_range(65, 127);
    end else begin
      n = $urandom_range(1, 64);
    end
    send_request(n, $urandom_range(0, 15) == 0);
  endtask

  // drain outstanding samples so the step can change while the block is idle
  task automatic settle();
    @(negedge clk);
    req_valid = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_step(input logic [21:0] value);
    settle();
    @(negedge clk);
    cfg_data  = value;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.set_step(value);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic random_phase(input logic [21:0] value, input int items, input int rate);
    write_step(value);
    idle_rate = rate;
    repeat (items) send_random();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset step: count extremes, oversized counts, zero counts with and without restart
    idle_rate = 4;
    send_request(7'd1, 1'b0);
    send_request(7'd0, 1'b0);
    send_request(7'd0, 1'b1);
    send_request(7'd64, 1'b0);
    send_request(7'd65, 1'b0);
    send_request(7'd127, 1'b1);
    send_request(7'd1, 1'b1);
    send_request(7'd33, 1'b0);

    // frozen pattern clock
    write_step(STEP_FROZEN);
    send_request(7'd5, 1'b1);
    send_request(7'd64, 1'b0);

    // widest step walks through attack, release and into the gap
    write_step(STEP_ALL_ONE);
    send_request(7'd64, 1'b1);
    repeat (14) send_request(7'd64, 1'b0);

    random_phase(STEP_LOWEST, 40, 3);
    random_phase(STEP_HIGHEST, 90, 6);
    random_phase(STEP_ALL_ONE, 110, 0);
    random_phase(22'($urandom_range(STEP_LOWEST, STEP_HIGHEST)), 60, 2);
    random_phase(22'($urandom_range(1, STEP_ALL_ONE)), 50, 8);
    random_phase(STEP_48K, 70, 0);

    settle();
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
